// ===== rtl/core/pcss_pkg.sv =====
// package with types and constants of the pump and chiller start/stop sequencer
`timescale 1ns / 1ps
`default_nettype none

package pcss_pkg;

  localparam int CHANNELS_DEF = 2;

  localparam int DELAY_W    = 10;
  localparam int TIMER_W    = 20;
  localparam int PCT_W      = 7;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int DIV_W      = 21;
  localparam int QUO_W      = 11;
  localparam int CNT_W      = 4;

  localparam int MS_PER_SECOND = 1000;
  localparam int FULL_PERCENT  = 100;
  localparam int MS_PER_PCT    = MS_PER_SECOND / FULL_PERCENT;
  localparam int DELAY_RESET   = 60;

  // quotient bits of the two divisions
  localparam int PCT_STEPS = 8;
  localparam int SEC_STEPS = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_ONE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_TWO = 1'b1;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MODE = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TWO  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SERVE,
    ST_PCT,
    ST_SEC,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/pump_chiller_start_stop_sequencer_core.sv =====
// two-channel pump and chiller start/stop sequencer with shared divide unit
// a mode word goes from ST_IDLE to ST_DONE, which loads the output; a tick word goes
//   via ST_SERVE and, if a channel is served, ST_PCT and ST_SEC; words are taken only
//   in ST_IDLE; one shared compare-subtract unit does 8 steps for percent, 11 for seconds
// a result held back by m_axis_tready keeps the core busy and s_axis_tready low
// reset: drives off, no requests, channels finished, timers zero, delays 60 s
`timescale 1ns / 1ps
`default_nettype none

module pump_chiller_start_stop_sequencer_core #(
  parameter int CHANNELS = pcss_pkg::CHANNELS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // input words
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [7:0]                           s_axis_tdata,  // mode
  input  wire  [0:0]                           s_axis_tuser,  // func
  // result words
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // pump_one_on, chiller_one_on, pump_two_on, chiller_two_on, served_channel,
  // progress_percent, seconds_waited
  output logic [23:0]                          m_axis_tdata,
  // configuration
  input  wire                                  cfg_we_i,
  input  wire  [pcss_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire  [pcss_pkg::DELAY_W-1:0]         cfg_wdata_i
);

  localparam int NumCh = (CHANNELS < 2) ? 1 : 2;
  localparam int TW    = pcss_pkg::TIMER_W;
  localparam int DW    = pcss_pkg::DELAY_W;
  localparam int VW    = pcss_pkg::DIV_W;
  localparam int QW    = pcss_pkg::QUO_W;
  localparam int CW    = pcss_pkg::CNT_W;
  localparam int PW    = pcss_pkg::PCT_W;
  localparam int MW    = pcss_pkg::MODE_W;
  localparam int PctShift = pcss_pkg::PCT_STEPS - 1;
  localparam int SecShift = pcss_pkg::SEC_STEPS - 1;
  localparam logic [VW-1:0] SecDiv = VW'(pcss_pkg::MS_PER_SECOND) << SecShift;

  pcss_pkg::state_e state_q, state_d;

  logic [DW-1:0]    delay_one_q, delay_one_d;
  logic [DW-1:0]    delay_two_q, delay_two_d;
  logic [NumCh-1:0] pump_q, pump_d;
  logic [NumCh-1:0] chill_q, chill_d;
  logic [NumCh-1:0] start_q, start_d;
  logic [NumCh-1:0] stop_q, stop_d;
  logic [NumCh-1:0] fin_q, fin_d;
  logic [TW-1:0]    elapsed_q [NumCh];
  logic [TW-1:0]    elapsed_d [NumCh];
  logic [MW-1:0]    prev_q, prev_d;

  logic [MW-1:0]    served_q, served_d;
  logic [PW-1:0]    pct_q, pct_d;
  logic [DW-1:0]    secs_q, secs_d;

  // divide unit scratch
  logic [TW-1:0]    e_q, e_d;
  logic [DW-1:0]    dsel_q, dsel_d;
  logic [TW-1:0]    rem_q, rem_d;
  logic [VW-1:0]    div_q, div_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic             out_valid_q, out_valid_d;
  logic [23:0]      out_data_q, out_data_d;

  // request selection
  logic [NumCh-1:0] start_first, stop_first, sel_oh;
  logic             sel_start, sel_found, sel_pump, sel_chill, sel_fin, sel_done;
  logic [MW-1:0]    sel_ch;
  logic [TW-1:0]    sel_e, e_new, limit;
  logic [DW-1:0]    sel_delay;
  logic [13:0]      sel_div;

  // shared compare-subtract unit
  logic             fits;
  logic [QW-1:0]    quo_next;

  // mode decode
  logic [MW-1:0]    mode_now;
  logic [1:0]       pump_ext, chill_ext;

  assign s_axis_tready = (state_q == pcss_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign pump_ext  = 2'(pump_q);
  assign chill_ext = 2'(chill_q);

  assign mode_now = ((s_axis_tdata[MW-1:0] == pcss_pkg::MODE_ONE ||
                      s_axis_tdata[MW-1:0] == pcss_pkg::MODE_TWO) &&
                     (32'(s_axis_tdata[MW-1:0]) <= CHANNELS)) ?
                    s_axis_tdata[MW-1:0] : pcss_pkg::MODE_NONE;

  assign fits     = {{(VW-TW){1'b0}}, rem_q} >= div_q;
  assign quo_next = {quo_q[QW-2:0], fits};

  always_comb begin
    start_first = '0;
    stop_first  = '0;
    sel_found   = 1'b0;
    for (int i = 0; i < NumCh; i++) begin
      if (start_q[i] && !sel_found) begin
        start_first[i] = 1'b1;
        sel_found      = 1'b1;
      end
    end
    sel_found = 1'b0;
    for (int i = 0; i < NumCh; i++) begin
      if (stop_q[i] && !sel_found) begin
        stop_first[i] = 1'b1;
        sel_found     = 1'b1;
      end
    end
    sel_start = |start_q;
    sel_oh    = sel_start ? start_first : stop_first;
    sel_ch    = pcss_pkg::MODE_NONE;
    sel_e     = '0;
    sel_pump  = 1'b0;
    sel_chill = 1'b0;
    sel_fin   = 1'b0;
    for (int i = 0; i < NumCh; i++) begin
      if (sel_oh[i]) begin
        sel_ch    = MW'(i + 1);
        sel_e     = elapsed_q[i];
        sel_pump  = pump_q[i];
        sel_chill = chill_q[i];
        sel_fin   = fin_q[i];
      end
    end
    sel_delay = (sel_ch == pcss_pkg::MODE_ONE) ? delay_one_q : delay_two_q;
    limit     = TW'(sel_delay * pcss_pkg::MS_PER_SECOND);
    sel_div   = 14'(sel_delay * pcss_pkg::MS_PER_PCT);
    e_new     = (!sel_fin && (sel_start ? !sel_pump : sel_chill)) ? '0 : sel_e;
    sel_done  = !sel_fin && (e_new > limit);
  end

  always_comb begin
    state_d     = state_q;
    delay_one_d = delay_one_q;
    delay_two_d = delay_two_q;
    pump_d      = pump_q;
    chill_d     = chill_q;
    start_d     = start_q;
    stop_d      = stop_q;
    fin_d       = fin_q;
    elapsed_d   = elapsed_q;
    prev_d      = prev_q;
    served_d    = served_q;
    pct_d       = pct_q;
    secs_d      = secs_q;
    e_d         = e_q;
    dsel_d      = dsel_q;
    rem_d       = rem_q;
    div_d       = div_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pcss_pkg::REG_DELAY_ONE: delay_one_d = cfg_wdata_i;
        pcss_pkg::REG_DELAY_TWO: delay_two_d = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      pcss_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser[0] == pcss_pkg::FUNC_MODE) begin
            for (int i = 0; i < NumCh; i++) begin
              if (mode_now == pcss_pkg::MODE_NONE) begin
                if (prev_q == MW'(i + 1)) begin
                  start_d[i] = 1'b0;
                  stop_d[i]  = 1'b1;
                  fin_d[i]   = 1'b0;
                end
              end else if (prev_q == pcss_pkg::MODE_NONE && mode_now == MW'(i + 1)) begin
                start_d[i] = 1'b1;
                fin_d[i]   = 1'b0;
              end
            end
            prev_d   = mode_now;
            served_d = pcss_pkg::MODE_NONE;
            pct_d    = '0;
            secs_d   = '0;
            state_d  = pcss_pkg::ST_DONE;
          end else begin
            for (int i = 0; i < NumCh; i++) begin
              if (elapsed_q[i] != '1) begin
                elapsed_d[i] = elapsed_q[i] + TW'(1);
              end
            end
            state_d = pcss_pkg::ST_SERVE;
          end
        end
      end

      pcss_pkg::ST_SERVE: begin
        served_d = sel_ch;
        dsel_d   = sel_delay;
        if (sel_oh == '0) begin
          pct_d   = '0;
          secs_d  = '0;
          state_d = pcss_pkg::ST_DONE;
        end else begin
          for (int i = 0; i < NumCh; i++) begin
            if (sel_oh[i]) begin
              elapsed_d[i] = e_new;
              if (sel_fin) begin
                if (sel_start) begin
                  start_d[i] = 1'b0;
                end else begin
                  stop_d[i] = 1'b0;
                end
              end else if (sel_start) begin
                pump_d[i] = 1'b1;
                if (sel_done) begin
                  chill_d[i] = 1'b1;
                  fin_d[i]   = 1'b1;
                  start_d[i] = 1'b0;
                end
              end else begin
                chill_d[i] = 1'b0;
                if (sel_done) begin
                  pump_d[i] = 1'b0;
                  fin_d[i]  = 1'b1;
                  stop_d[i] = 1'b0;
                end
              end
            end
          end
          e_d     = e_new;
          rem_d   = e_new;
          div_d   = VW'(sel_div) << PctShift;
          quo_d   = '0;
          cnt_d   = CW'(PctShift);
          state_d = pcss_pkg::ST_PCT;
        end
      end

      pcss_pkg::ST_PCT, pcss_pkg::ST_SEC: begin
        rem_d = fits ? (rem_q - div_q[TW-1:0]) : rem_q;
        div_d = div_q >> 1;
        quo_d = quo_next;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          if (state_q == pcss_pkg::ST_PCT) begin
            pct_d   = (quo_next[7:0] > 8'(pcss_pkg::FULL_PERCENT)) ?
                      PW'(pcss_pkg::FULL_PERCENT) : quo_next[PW-1:0];
            rem_d   = e_q;
            div_d   = SecDiv;
            quo_d   = '0;
            cnt_d   = CW'(SecShift);
            state_d = pcss_pkg::ST_SEC;
          end else begin
            secs_d  = (quo_next > {1'b0, dsel_q}) ? dsel_q : quo_next[DW-1:0];
            state_d = pcss_pkg::ST_DONE;
          end
        end
      end

      pcss_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, secs_q, pct_q, served_q,
                         chill_ext[1], pump_ext[1], chill_ext[0], pump_ext[0]};
          state_d     = pcss_pkg::ST_IDLE;
        end
      end

      default: state_d = pcss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcss_pkg::ST_IDLE;
      delay_one_q <= DW'(pcss_pkg::DELAY_RESET);
      delay_two_q <= DW'(pcss_pkg::DELAY_RESET);
      pump_q      <= '0;
      chill_q     <= '0;
      start_q     <= '0;
      stop_q      <= '0;
      fin_q       <= '1;
      for (int i = 0; i < NumCh; i++) begin
        elapsed_q[i] <= '0;
      end
      prev_q      <= pcss_pkg::MODE_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      delay_one_q <= delay_one_d;
      delay_two_q <= delay_two_d;
      pump_q      <= pump_d;
      chill_q     <= chill_d;
      start_q     <= start_d;
      stop_q      <= stop_d;
      fin_q       <= fin_d;
      elapsed_q   <= elapsed_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    served_q   <= served_d;
    pct_q      <= pct_d;
    secs_q     <= secs_d;
    e_q        <= e_d;
    dsel_q     <= dsel_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
  end

  // checks
  for (genvar g = 0; g < NumCh; g++) begin : g_chk
    a_chiller_needs_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
      chill_q[g] |-> pump_q[g])
      else $error("chiller on while its pump is off");

    a_finished_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
      fin_q[g] |-> (pump_q[g] == chill_q[g]))
      else $error("finished channel has pump and chiller in different states");
  end

  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while one is in work");

  a_pct_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[12:6] <= 7'd100))
    else $error("progress percent above full");

endmodule

`default_nettype wire

// ===== test/tb_pump_chiller_start_stop_sequencer_core.sv =====
// testbench for the pump and chiller start/stop sequencer core
`timescale 1ns / 1ps

module tb_pump_chiller_start_stop_sequencer_core;
  import pcss_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int unsigned TIMER_MAX = (1 << TIMER_W) - 1;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic               pad;
    logic [DELAY_W-1:0] secs;
    logic [PCT_W-1:0]   pct;
    logic [MODE_W-1:0]  served;
    logic               chiller_two;
    logic               pump_two;
    logic               chiller_one;
    logic               pump_one;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // mode
  logic [0:0] s_axis_tuser = '0;   // func
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // pump_one_on, chiller_one_on, pump_two_on, chiller_two_on, served_channel,
  // progress_percent, seconds_waited
  logic [23:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [DELAY_W-1:0] cfg_wdata_i = '0;

  // predicted sequencer state
  logic [DELAY_W-1:0] delay_s [2] = '{DELAY_W'(DELAY_RESET), DELAY_W'(DELAY_RESET)};
  bit pump_on [2] = '{1'b0, 1'b0};
  bit chiller_on [2] = '{1'b0, 1'b0};
  bit start_req [2] = '{1'b0, 1'b0};
  bit stop_req [2] = '{1'b0, 1'b0};
  bit seq_done [2] = '{1'b1, 1'b1};
  int unsigned elapsed [2] = '{0, 0};
  int unsigned last_mode = 0;

  status_t status_due_q [$];
  status_t seen, want;
  int mismatches = 0;
  bit idling_on = 1'b1;
  int sink_hold_req = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  pump_chiller_start_stop_sequencer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic status_t advance_sequencer(input logic func, input logic [MODE_W-1:0] mode);
    status_t r;
    int unsigned now, ch, i;
    bit starting;
    longint unsigned limit, e, p;
    r = '0;
    ch = 0;
    starting = 1'b0;
    if (func == FUNC_MODE) begin
      now = (mode == MODE_ONE || mode == MODE_TWO) ? mode : 0;
      if (now == 0) begin
        if (last_mode != 0) begin
          i = last_mode - 1;
          start_req[i] = 1'b0;
          stop_req[i] = 1'b1;
          seq_done[i] = 1'b0;
        end
      end else if (last_mode == 0) begin
        start_req[now - 1] = 1'b1;
        seq_done[now - 1] = 1'b0;
      end
      last_mode = now;
    end else begin
      for (int c = 0; c < 2; c++)
        if (elapsed[c] < TIMER_MAX) elapsed[c]++;
      for (int c = 0; c < 2; c++)
        if (ch == 0 && start_req[c]) begin
          ch = c + 1;
          starting = 1'b1;
        end
      for (int c = 0; c < 2; c++)
        if (ch == 0 && stop_req[c]) ch = c + 1;
      if (ch != 0) begin
        i = ch - 1;
        limit = longint'(delay_s[i]) * MS_PER_SECOND;
        if (seq_done[i]) begin
          if (starting) start_req[i] = 1'b0;
          else stop_req[i] = 1'b0;
        end else if (starting) begin
          if (!pump_on[i]) begin
            pump_on[i] = 1'b1;
            elapsed[i] = 0;
          end
          if (elapsed[i] > limit) begin
            chiller_on[i] = 1'b1;
            seq_done[i] = 1'b1;
            start_req[i] = 1'b0;
          end
        end else begin
          if (chiller_on[i]) begin
            chiller_on[i] = 1'b0;
            elapsed[i] = 0;
          end
          if (elapsed[i] > limit) begin
            pump_on[i] = 1'b0;
            seq_done[i] = 1'b1;
            stop_req[i] = 1'b0;
          end
        end
        e = elapsed[i];
        if (delay_s[i] == 0) begin
          r.pct = PCT_W'(FULL_PERCENT);
        end else begin
          p = (e * FULL_PERCENT) / limit;
          r.pct = (p > FULL_PERCENT) ? PCT_W'(FULL_PERCENT) : PCT_W'(p);
        end
        e = e / MS_PER_SECOND;
        r.secs = (e > delay_s[i]) ? delay_s[i] : DELAY_W'(e);
        r.served = MODE_W'(ch);
      end
    end
    r.pump_one = pump_on[0];
    r.chiller_one = chiller_on[0];
    r.pump_two = pump_on[1];
    r.chiller_two = chiller_on[1];
    return r;
  endfunction

  function automatic int idle_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int burst_len();
    if ($urandom_range(0, 99) < 8) return $urandom_range(10, 30);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 6) return DELAY_W'(1);
    if (r < 8) return DELAY_W'($urandom_range(2, 5));
    return DELAY_W'($urandom_range(0, 1023));
  endfunction

  task automatic send_word(input logic func, input logic [MODE_W-1:0] mode);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 99) < 40) gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, mode};
    s_axis_tuser <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    status_due_q.push_back(advance_sequencer(func, mode));
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_word(FUNC_TICK, MODE_W'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_delay(input logic [CFG_ADDR_W-1:0] idx, input logic [DELAY_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == REG_DELAY_ONE) delay_s[0] = value;
    else delay_s[1] = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_idle_words();
    send_ticks(1);
    send_word(FUNC_MODE, MODE_NONE);
    send_word(FUNC_MODE, MODE_SPARE);
    send_ticks(1);
  endtask

  task automatic test_zero_delay_sequences();
    drain();
    write_delay(REG_DELAY_ONE, '0);
    write_delay(REG_DELAY_TWO, '0);
    send_word(FUNC_MODE, MODE_ONE);
    send_ticks(3);
    send_word(FUNC_MODE, MODE_TWO);
    send_word(FUNC_MODE, MODE_SPARE);
    send_ticks(1);
    send_word(FUNC_MODE, MODE_TWO);
    send_ticks(2);
    send_word(FUNC_MODE, MODE_NONE);
    send_ticks(2);
  endtask

  // start requested again while the stop of the same channel still waits
  task automatic test_finished_channel_request();
    send_word(FUNC_MODE, MODE_ONE);
    send_word(FUNC_MODE, MODE_NONE);
    send_word(FUNC_MODE, MODE_ONE);
    send_ticks(3);
  endtask

  task automatic test_one_second_sequences();
    drain();
    write_delay(REG_DELAY_ONE, DELAY_W'(1));
    write_delay(REG_DELAY_TWO, '0);
    send_word(FUNC_MODE, MODE_NONE);
    send_ticks(30);
    send_word(FUNC_MODE, MODE_ONE);
    send_ticks(30);
  endtask

  task automatic test_delay_extremes();
    drain();
    write_delay(REG_DELAY_ONE, DELAY_W'(999));
    write_delay(REG_DELAY_TWO, '1);
    send_word(FUNC_MODE, MODE_TWO);
    send_word(FUNC_MODE, MODE_NONE);
    send_ticks(3);
    send_word(FUNC_MODE, MODE_ONE);
    send_ticks(3);
  endtask

  task automatic test_backpressure();
    drain();
    idling_on = 1'b0;
    sink_hold_req = 300;
    for (int n = 0; n < 24; n++)
      if (n % 3 == 0) send_ticks(1);
      else send_word(FUNC_MODE, MODE_W'($urandom_range(0, 3)));
    drain();
    idling_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [MODE_W-1:0] ch, other;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_delay(REG_DELAY_ONE, pick_delay());
      write_delay(REG_DELAY_TWO, pick_delay());
      idling_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 10; n++) begin
        ch = $urandom_range(0, 1) ? MODE_TWO : MODE_ONE;
        other = (ch == MODE_ONE) ? MODE_TWO : MODE_ONE;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            send_word(FUNC_MODE, ch);
            send_ticks(burst_len());
            send_word(FUNC_MODE, $urandom_range(0, 1) ? MODE_NONE : MODE_SPARE);
            send_ticks(burst_len());
          end
          6, 7: begin
            send_word(FUNC_MODE, ch);
            send_word(FUNC_MODE, other);
            send_ticks(burst_len());
            send_word(FUNC_MODE, MODE_NONE);
            send_ticks(burst_len());
          end
          default: begin
            send_word(1'($urandom_range(0, 1)), MODE_W'($urandom_range(0, 3)));
          end
        endcase
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      hold = 0;
      if (sink_hold_req != 0) begin
        hold = sink_hold_req;
        sink_hold_req = 0;
      end else if (idling_on && $urandom_range(0, 99) < 15) begin
        hold = idle_gap();
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (status_due_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected word %h", $time, m_axis_tdata);
      end else begin
        want = status_due_q.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 20)
            $display({"%0t mismatch: expected p1 %b c1 %b p2 %b c2 %b ch %0d pct %0d",
                      " sec %0d pad %b, actual p1 %b c1 %b p2 %b c2 %b ch %0d pct %0d",
                      " sec %0d pad %b"}, $time,
                     want.pump_one, want.chiller_one, want.pump_two, want.chiller_two,
                     want.served, want.pct, want.secs, want.pad,
                     seen.pump_one, seen.chiller_one, seen.pump_two, seen.chiller_two,
                     seen.served, seen.pct, seen.secs, seen.pad);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_words();
    test_zero_delay_sequences();
    test_finished_channel_request();
    test_one_second_sequences();
    test_delay_extremes();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(64'd100_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
